[rtl/core/priority_queue_sorted_insert_macros.svh]
// ----------------------------------------------------------------------------
// Priority queue assertion macros
// Shared property forms for the sorted-insert priority queue checks.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_QUEUE_SORTED_INSERT_MACROS_SVH
`define PRIORITY_QUEUE_SORTED_INSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PQSI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pqsi: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PQSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pqsi: next-cycle check failed");

`endif

[rtl/core/pqsi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority queue package
// Widths, command and status codes, and sequencer states of the queue.
// ----------------------------------------------------------------------------
package pqsi_pkg;

   localparam int CAPACITY_DEF       = 16;
   localparam int PRIORITY_BITS_DEF  = 8;
   localparam int VALUE_BITS         = 32;
   localparam int PRIORITY_PORT_BITS = 8;
   localparam int COUNT_BITS         = 5;
   localparam int CMD_BITS           = 2;
   localparam int STATUS_BITS        = 2;

   localparam logic [CMD_BITS-1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR   = 2'd2;

   localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENQ_CMP,
      ST_ENQ_PLACE,
      ST_DEQ_HEAD,
      ST_FINISH
   } pqsi_state_type;

endpackage

[rtl/core/priority_queue_sorted_insert.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted-insert priority queue
// Bounded max-priority queue held as a sorted ring in one RAM.
// ----------------------------------------------------------------------------
//   Channel   Direction   Handshake             Word
//   req       in          req_valid/req_stall   cmd, value, priority_req
//   rsp       out         rsp_valid/rsp_stall   deq_value, deq_valid, status,
//                                               count, is_empty, head_value
//
// Insertion walks the list from its tail one entry a cycle through the single
// RAM read port and one priority comparator.
// Reset clears the count and the sequencer; the store itself is not cleared.
// A finished word waits in the result register; the next request word is
// taken once that register has been loaded.
// ----------------------------------------------------------------------------
`include "priority_queue_sorted_insert_macros.svh"

module priority_queue_sorted_insert #(
   parameter int CAPACITY      = pqsi_pkg::CAPACITY_DEF,
   parameter int PRIORITY_BITS = pqsi_pkg::PRIORITY_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic [pqsi_pkg::CMD_BITS-1:0]              req_cmd,
   input  logic signed [pqsi_pkg::VALUE_BITS-1:0]     req_value,
   input  logic [pqsi_pkg::PRIORITY_PORT_BITS-1:0]    req_priority_req,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic signed [pqsi_pkg::VALUE_BITS-1:0]     rsp_deq_value,
   output logic                                       rsp_deq_valid,
   output logic [pqsi_pkg::STATUS_BITS-1:0]           rsp_status,
   output logic [pqsi_pkg::COUNT_BITS-1:0]            rsp_count,
   output logic                                       rsp_is_empty,
   output logic signed [pqsi_pkg::VALUE_BITS-1:0]     rsp_head_value
);

   localparam int VW       = pqsi_pkg::VALUE_BITS;
   localparam int COUNT_W  = pqsi_pkg::COUNT_BITS;
   localparam int AW       = $clog2(CAPACITY);
   localparam int OCC_BITS = $clog2(CAPACITY + 1);
   localparam int SW       = $clog2(2 * CAPACITY);
   localparam int EW       = VW + PRIORITY_BITS;

   pqsi_pkg::pqsi_state_type state_ff, state_in;

   logic [OCC_BITS-1:0]              occ_ff, occ_in;
   logic [AW-1:0]                    base_ff, base_in;
   logic [OCC_BITS-1:0]              i_ff, i_in;
   logic signed [VW-1:0]             head_ff, head_in;
   logic signed [VW-1:0]             value_ff, value_in;
   logic [PRIORITY_BITS-1:0]         prio_ff, prio_in;
   logic [pqsi_pkg::STATUS_BITS-1:0] stat_ff, stat_in;
   logic signed [VW-1:0]             dqv_ff, dqv_in;
   logic                             dqok_ff, dqok_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [VW-1:0]             rsp_deq_value_ff, rsp_deq_value_in;
   logic                             rsp_deq_valid_ff, rsp_deq_valid_in;
   logic [pqsi_pkg::STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]               rsp_count_ff, rsp_count_in;
   logic                             rsp_is_empty_ff, rsp_is_empty_in;
   logic signed [VW-1:0]             rsp_head_value_ff, rsp_head_value_in;

   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [EW-1:0]            wr_data;
   logic [OCC_BITS-1:0]      rd_k;
   logic [AW-1:0]            rd_addr;
   logic [EW-1:0]            rd_data;
   logic [PRIORITY_BITS-1:0] rd_prio;

   // Physical RAM slot of list position k, counted from the ring base.
   function automatic logic [AW-1:0] slot(input logic [AW-1:0] b,
                                          input logic [OCC_BITS-1:0] k);
      logic [SW-1:0] s;
      s = SW'(b) + SW'(k);
      if (s >= SW'(CAPACITY)) begin
         s = s - SW'(CAPACITY);
      end
      return AW'(s);
   endfunction

   pqsi_ram #(
      .WIDTH (EW),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_prio = rd_data[EW-1:VW];
   assign rd_addr = slot(base_ff, rd_k);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pqsi_pkg::ST_IDLE;
         occ_ff       <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff              <= i_in;
      head_ff           <= head_in;
      value_ff          <= value_in;
      prio_ff           <= prio_in;
      stat_ff           <= stat_in;
      dqv_ff            <= dqv_in;
      dqok_ff           <= dqok_in;
      rsp_deq_value_ff  <= rsp_deq_value_in;
      rsp_deq_valid_ff  <= rsp_deq_valid_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_count_ff      <= rsp_count_in;
      rsp_is_empty_ff   <= rsp_is_empty_in;
      rsp_head_value_ff <= rsp_head_value_in;
   end

   always_comb begin
      state_in          = state_ff;
      occ_in            = occ_ff;
      base_in           = base_ff;
      i_in              = i_ff;
      head_in           = head_ff;
      value_in          = value_ff;
      prio_in           = prio_ff;
      stat_in           = stat_ff;
      dqv_in            = dqv_ff;
      dqok_in           = dqok_ff;
      rsp_valid_in      = rsp_valid_ff & rsp_stall;
      rsp_deq_value_in  = rsp_deq_value_ff;
      rsp_deq_valid_in  = rsp_deq_valid_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_count_in      = rsp_count_ff;
      rsp_is_empty_in   = rsp_is_empty_ff;
      rsp_head_value_in = rsp_head_value_ff;
      wr_en             = 1'b0;
      wr_addr           = slot(base_ff, i_ff);
      wr_data           = {prio_ff, value_ff};
      rd_k              = i_ff - OCC_BITS'(2);

      case (state_ff)
         pqsi_pkg::ST_IDLE: begin
            // Start the first read at once: the tail entry for an enqueue,
            // the entry behind the head for a dequeue.
            if (req_cmd == pqsi_pkg::CMD_DEQUEUE) begin
               rd_k = OCC_BITS'(1);
            end else begin
               rd_k = occ_ff - OCC_BITS'(1);
            end
            if (req_valid) begin
               value_in = req_value;
               prio_in  = PRIORITY_BITS'(req_priority_req);
               stat_in  = pqsi_pkg::STAT_OK;
               dqv_in   = '0;
               dqok_in  = 1'b0;
               state_in = pqsi_pkg::ST_FINISH;
               case (req_cmd)
                  pqsi_pkg::CMD_ENQUEUE: begin
                     i_in = occ_ff;
                     if (occ_ff == OCC_BITS'(CAPACITY)) begin
                        stat_in = pqsi_pkg::STAT_FULL;
                     end else if (occ_ff == '0) begin
                        state_in = pqsi_pkg::ST_ENQ_PLACE;
                     end else begin
                        state_in = pqsi_pkg::ST_ENQ_CMP;
                     end
                  end
                  pqsi_pkg::CMD_DEQUEUE: begin
                     if (occ_ff == '0) begin
                        stat_in = pqsi_pkg::STAT_EMPTY;
                     end else begin
                        dqv_in  = head_ff;
                        dqok_in = 1'b1;
                        base_in = slot(base_ff, OCC_BITS'(1));
                        occ_in  = occ_ff - OCC_BITS'(1);
                        if (occ_ff != OCC_BITS'(1)) begin
                           state_in = pqsi_pkg::ST_DEQ_HEAD;
                        end
                     end
                  end
                  pqsi_pkg::CMD_CLEAR: begin
                     occ_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         pqsi_pkg::ST_ENQ_CMP: begin
            wr_en = 1'b1;
            if (rd_prio < prio_ff) begin
               // Lower priority: move the entry one place back and go on.
               wr_data = rd_data;
               i_in    = i_ff - OCC_BITS'(1);
               if (i_ff == OCC_BITS'(1)) begin
                  state_in = pqsi_pkg::ST_ENQ_PLACE;
               end
            end else begin
               occ_in   = occ_ff + OCC_BITS'(1);
               state_in = pqsi_pkg::ST_FINISH;
            end
         end
         pqsi_pkg::ST_ENQ_PLACE: begin
            // The new entry lands at the front.
            wr_en    = 1'b1;
            head_in  = value_ff;
            occ_in   = occ_ff + OCC_BITS'(1);
            state_in = pqsi_pkg::ST_FINISH;
         end
         pqsi_pkg::ST_DEQ_HEAD: begin
            head_in  = rd_data[VW-1:0];
            state_in = pqsi_pkg::ST_FINISH;
         end
         pqsi_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_deq_value_in  = dqv_ff;
               rsp_deq_valid_in  = dqok_ff;
               rsp_status_in     = stat_ff;
               rsp_count_in      = COUNT_W'(occ_ff);
               rsp_is_empty_in   = (occ_ff == '0);
               rsp_head_value_in = (occ_ff != '0) ? head_ff : '0;
               state_in          = pqsi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pqsi_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall      = (state_ff != pqsi_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_deq_value  = rsp_deq_value_ff;
   assign rsp_deq_valid  = rsp_deq_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_is_empty   = rsp_is_empty_ff;
   assign rsp_head_value = rsp_head_value_ff;

   `PQSI_ASSERT_SAME(a_occ_bound, clock, reset, 1'b1, occ_ff <= OCC_BITS'(CAPACITY))
   `PQSI_ASSERT_SAME(a_walk_index, clock, reset, state_ff == pqsi_pkg::ST_ENQ_CMP, i_ff != '0)
   `PQSI_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, state_ff != pqsi_pkg::ST_IDLE)
   `PQSI_ASSERT_SAME(a_full_count, clock, reset, state_ff == pqsi_pkg::ST_FINISH && stat_ff == pqsi_pkg::STAT_FULL, occ_ff == OCC_BITS'(CAPACITY))
   `PQSI_ASSERT_SAME(a_deq_ok, clock, reset, rsp_valid_ff && rsp_deq_valid_ff, rsp_status_ff == pqsi_pkg::STAT_OK)

endmodule

[rtl/core/pqsi_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module pqsi_ram #(
   parameter int WIDTH = pqsi_pkg::VALUE_BITS + pqsi_pkg::PRIORITY_BITS_DEF,
   parameter int DEPTH = pqsi_pkg::CAPACITY_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[test/pqsi_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority queue scoreboard
// Keeps a sorted model of the queue and checks each result word against it.
// ----------------------------------------------------------------------------
package pqsi_tb_pkg;

   import pqsi_pkg::*;

   // Command code with no operation behind it; the queue must report and hold.
   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

   localparam logic [PRIORITY_PORT_BITS-1:0] PRIO_MASK =
      PRIORITY_PORT_BITS'((1 << PRIORITY_BITS_DEF) - 1);

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] deq_value;
      logic                         deq_valid;
      logic [STATUS_BITS-1:0]       status;
      logic [COUNT_BITS-1:0]        count;
      logic                         is_empty;
      logic signed [VALUE_BITS-1:0] head_value;
   } pq_result_t;

   class pq_scoreboard;

      logic signed [VALUE_BITS-1:0]   stored_value[CAPACITY_DEF];
      logic [PRIORITY_PORT_BITS-1:0]  stored_prio[CAPACITY_DEF];
      int unsigned                    occupancy = 0;
      pq_result_t                     expected_q[$];

      int unsigned errors = 0;
      int unsigned words_checked = 0;
      int unsigned n_enqueue = 0;
      int unsigned n_full = 0;
      int unsigned n_dequeue = 0;
      int unsigned n_empty = 0;
      int unsigned n_clear = 0;
      int unsigned n_unused = 0;
      int unsigned n_reached_full = 0;

      // Updates the sorted model with one accepted command word and queues the
      // result word it must produce.
      function void apply_command(logic [CMD_BITS-1:0] cmd,
                                  logic signed [VALUE_BITS-1:0] value,
                                  logic [PRIORITY_PORT_BITS-1:0] prio);
         pq_result_t                    want;
         logic [PRIORITY_PORT_BITS-1:0] p;
         int unsigned                   pos;
         want = '0;
         p = prio & PRIO_MASK;
         case (cmd)
            CMD_ENQUEUE: begin
               n_enqueue++;
               if (occupancy >= CAPACITY_DEF) begin
                  want.status = STAT_FULL;
                  n_full++;
               end else begin
                  // A new entry goes behind every entry of equal or higher priority.
                  pos = 0;
                  while (pos < occupancy && stored_prio[pos] >= p) pos++;
                  for (int unsigned i = occupancy; i > pos; i--) begin
                     stored_value[i] = stored_value[i-1];
                     stored_prio[i]  = stored_prio[i-1];
                  end
                  stored_value[pos] = value;
                  stored_prio[pos]  = p;
                  occupancy++;
                  if (occupancy == CAPACITY_DEF) n_reached_full++;
               end
            end
            CMD_DEQUEUE: begin
               n_dequeue++;
               if (occupancy == 0) begin
                  want.status = STAT_EMPTY;
                  n_empty++;
               end else begin
                  want.deq_value = stored_value[0];
                  want.deq_valid = 1'b1;
                  for (int unsigned i = 0; i + 1 < occupancy; i++) begin
                     stored_value[i] = stored_value[i+1];
                     stored_prio[i]  = stored_prio[i+1];
                  end
                  occupancy--;
               end
            end
            CMD_CLEAR: begin
               n_clear++;
               occupancy = 0;
            end
            default: n_unused++;
         endcase
         want.count      = occupancy[COUNT_BITS-1:0];
         want.is_empty   = (occupancy == 0);
         want.head_value = (occupancy != 0) ? stored_value[0] : '0;
         expected_q.push_back(want);
      endfunction

      function int unsigned outstanding();
         return expected_q.size();
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         end
      endfunction

      function void check_result(pq_result_t got);
         pq_result_t want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result word with none expected, expected nothing, actual %h",
                     $time, got);
            return;
         end
         want = expected_q.pop_front();
         words_checked++;
         compare_field("deq_value", 32'(want.deq_value), 32'(got.deq_value));
         compare_field("deq_valid", 32'(want.deq_valid), 32'(got.deq_valid));
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("count", 32'(want.count), 32'(got.count));
         compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
         compare_field("head_value", 32'(want.head_value), 32'(got.head_value));
      endfunction

   endclass

endpackage

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority queue testbench
// Drives enqueue, dequeue, clear and unused command words into the queue with
// random idling on both channels and checks every result word in order.
// ----------------------------------------------------------------------------
module tb;

   import pqsi_pkg::*;
   import pqsi_tb_pkg::*;

   localparam int RANDOM_ITEMS = 1600;
   localparam int PHASE_ITEMS  = 40;
   localparam int QUIET_ITEMS  = 150;
   localparam int LONG_HOLD    = 400;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_e;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [CMD_BITS-1:0]                req_cmd = CMD_ENQUEUE;
   logic signed [VALUE_BITS-1:0]       req_value = '0;
   logic [PRIORITY_PORT_BITS-1:0]      req_priority_req = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic signed [VALUE_BITS-1:0]       rsp_deq_value;
   logic                               rsp_deq_valid;
   logic [STATUS_BITS-1:0]             rsp_status;
   logic [COUNT_BITS-1:0]              rsp_count;
   logic                               rsp_is_empty;
   logic signed [VALUE_BITS-1:0]       rsp_head_value;

   bit          idling_on = 1'b1;
   bit          long_hold_req = 1'b0;
   int unsigned cycle_count = 0;
   pq_scoreboard sb;

   priority_queue_sorted_insert i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_value        (req_value),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_deq_value    (rsp_deq_value),
      .rsp_deq_valid    (rsp_deq_valid),
      .rsp_status       (rsp_status),
      .rsp_count        (rsp_count),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_head_value   (rsp_head_value)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("priority_queue_sorted_insert test failed");
         $finish;
      end
   end

   // Offers one word and holds it until the queue takes it.
   task automatic send_word(input logic [CMD_BITS-1:0] cmd,
                            input logic signed [VALUE_BITS-1:0] value,
                            input logic [PRIORITY_PORT_BITS-1:0] prio);
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_value        <= value;
      req_priority_req <= prio;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.apply_command(cmd, value, prio);
   endtask

   task automatic sender_gap(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Result side: checks each accepted word and decides the stall for the next cycle.
   initial begin : result_sink
      int hold_left;
      int burst_left;
      pq_result_t got;
      hold_left = 0;
      burst_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
            got.deq_value  = rsp_deq_value;
            got.deq_valid  = rsp_deq_valid;
            got.status     = rsp_status;
            got.count      = rsp_count;
            got.is_empty   = rsp_is_empty;
            got.head_value = rsp_head_value;
            sb.check_result(got);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD - 1;
            rsp_stall <= 1'b1;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(1, 14) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      int                            sent;
      int                            phase;
      int                            roll;
      int                            enq_pct;
      int                            prio_style;
      traffic_mode_e                 mode;
      logic [CMD_BITS-1:0]           cmd;
      logic signed [VALUE_BITS-1:0]  value;
      logic [PRIORITY_PORT_BITS-1:0] prio;

      sb = new;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed words: empty-queue cases, extreme values and priorities, equal
      // priorities that must leave in arrival order, a full queue and a clear.
      send_word(CMD_DEQUEUE, 32'sh1234_5678, 8'd7);
      send_word(CMD_UNUSED, 32'sh7FFF_FFFF, 8'hFF);
      send_word(CMD_ENQUEUE, 32'sh7FFF_FFFF, 8'd255);
      send_word(CMD_ENQUEUE, 32'sh8000_0000, 8'd0);
      send_word(CMD_ENQUEUE, 32'sh0000_0000, 8'd128);
      send_word(CMD_ENQUEUE, -32'sd1, 8'd128);
      send_word(CMD_ENQUEUE, 32'sh0000_0001, 8'd128);
      send_word(CMD_ENQUEUE, 32'shAAAA_AAAA, 8'd255);
      for (int i = 0; i < 10; i++)
         send_word(CMD_ENQUEUE, 32'sh5555_5555 ^ (i * 32'sh0101_0101), 8'((i % 3) * 85));
      send_word(CMD_ENQUEUE, 32'sh0BAD_F00D, 8'd255);
      send_word(CMD_UNUSED, 32'sh0, 8'd0);
      repeat (3) send_word(CMD_DEQUEUE, 32'sh0, 8'd0);
      send_word(CMD_CLEAR, -32'sd1, 8'hAA);
      send_word(CMD_DEQUEUE, 32'sh0, 8'h55);

      // Random phases that swing between filling, draining and mixed traffic.
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         if (phase == 6) wait_drained();
         if (phase == 3) long_hold_req = 1'b1;
         mode = traffic_mode_e'($urandom_range(0, 2));
         enq_pct = (mode == MODE_FILL) ? 78 : (mode == MODE_DRAIN) ? 20 : 49;
         prio_style = $urandom_range(0, 2);
         idling_on = (phase != 3) && ($urandom_range(0, 3) != 0);
         for (int k = 0; k < PHASE_ITEMS && sent < RANDOM_ITEMS; k++) begin
            if (sent >= RANDOM_ITEMS - QUIET_ITEMS) idling_on = 1'b0;
            roll = $urandom_range(0, 99);
            if (roll < 1) cmd = CMD_CLEAR;
            else if (roll < 2) cmd = CMD_UNUSED;
            else if (roll < 2 + enq_pct) cmd = CMD_ENQUEUE;
            else cmd = CMD_DEQUEUE;
            case ($urandom_range(0, 15))
               0: value = 32'sh7FFF_FFFF;
               1: value = 32'sh8000_0000;
               2: value = '0;
               3: value = -32'sd1;
               default: value = $urandom;
            endcase
            // Narrow priority ranges make ties common, which is where order matters.
            case (prio_style)
               0: prio = PRIORITY_PORT_BITS'($urandom_range(0, 255));
               1: prio = PRIORITY_PORT_BITS'($urandom_range(0, 3));
               default: prio = PRIORITY_PORT_BITS'($urandom_range(252, 255));
            endcase
            if (idling_on && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 14));
            send_word(cmd, value, prio);
            sent++;
         end
         phase++;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d enqueues (%0d refused as full, queue filled %0d times), %0d dequeues",
               sb.n_enqueue, sb.n_full, sb.n_reached_full, sb.n_dequeue);
      $display("(%0d on an empty queue), %0d clears and %0d unused commands; %0d words checked.",
               sb.n_empty, sb.n_clear, sb.n_unused, sb.words_checked);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("priority_queue_sorted_insert test passed");
      end else begin
         $display("priority_queue_sorted_insert test failed");
      end
      $finish;
   end

endmodule
